// ===== hdl/nwg_pkg.sv =====
// Shared types and constants of the Nuttall window generator.
// No dependencies; every other file in hdl imports this package.
package nwg_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS = 30;
  localparam int COEF_BITS = 30;
  localparam int WORD_W    = 32;
  localparam int LEN_W     = 16;
  localparam int VALUE_W   = 31;
  localparam int INDEX_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_BITS_DEF = 16;

  // Window coefficients: a0 in Q.FRAC_BITS, a1..a3 in Q.COEF_BITS, rounded to nearest.
  localparam logic signed [63:0] A0_F =
      64'(((64'd355768 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic signed [63:0] A1_C =
      64'(((64'd487396 << COEF_BITS) + 64'd500000) / 64'd1000000);
  localparam logic signed [63:0] A2_C =
      64'(((64'd144232 << COEF_BITS) + 64'd500000) / 64'd1000000);
  localparam logic signed [63:0] A3_C =
      64'(((64'd12604 << COEF_BITS) + 64'd500000) / 64'd1000000);

  localparam logic signed [63:0] ONE_VAL = 64'sd1 <<< FRAC_BITS;
  localparam logic [VALUE_W-1:0] WIN_ONE = ONE_VAL[VALUE_W-1:0];

  // Rotator restart value: 1.0 saturated to a signed 32-bit word.
  localparam logic signed [WORD_W-1:0] ROT_ONE =
      (FRAC_BITS >= 31) ? 32'sh7FFF_FFFF : ONE_VAL[WORD_W-1:0];

  // Reset value of the step registers: 1.0 in Q1.30.
  localparam logic signed [WORD_W-1:0] STEP_ONE = 32'sh4000_0000;
  localparam logic [LEN_W-1:0] LEN_RESET = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH  = 3'd0,
    REG_COS_STEP_ONE   = 3'd1,
    REG_SIN_STEP_ONE   = 3'd2,
    REG_COS_STEP_TWO   = 3'd3,
    REG_SIN_STEP_TWO   = 3'd4,
    REG_COS_STEP_THREE = 3'd5,
    REG_SIN_STEP_THREE = 3'd6
  } cfg_reg_e;

  // Per-transaction control of a rotator.
  typedef struct packed {
    logic advance;  // a transaction is accepted this cycle
    logic restart;  // start from (1,0) before this sample
    logic rewind;   // return to (1,0) after this sample instead of turning
  } rot_ctrl_t;

  typedef struct packed {
    logic               last;
    logic [INDEX_W-1:0] sample_index;
    logic [VALUE_W-1:0] window_value;
  } out_item_t;

endpackage

// ===== hdl/nwg_rotator.sv =====
// One recursive rotator (cosine/sine pair) with rounding and saturation.
// Depends on nwg_pkg.
module nwg_rotator import nwg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rot_ctrl_t                ctrl_i,
  input  logic signed [WORD_W-1:0] cos_step_i,
  input  logic signed [WORD_W-1:0] sin_step_i,
  output logic signed [WORD_W-1:0] cos_o
);

  localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  logic signed [WORD_W-1:0] cos_q, cos_d, sin_q, sin_d;
  logic signed [WORD_W-1:0] cos_pre, sin_pre, cos_rot, sin_rot;
  logic signed [63:0] cc, ss, sc, cs;
  logic signed [65:0] sum_c, sum_s, shf_c, shf_s;

  assign cos_pre = ctrl_i.restart ? ROT_ONE : cos_q;
  assign sin_pre = ctrl_i.restart ? '0 : sin_q;
  assign cos_o   = cos_pre;

  assign cc = 64'(cos_pre) * 64'(cos_step_i);
  assign ss = 64'(sin_pre) * 64'(sin_step_i);
  assign sc = 64'(sin_pre) * 64'(cos_step_i);
  assign cs = 64'(cos_pre) * 64'(sin_step_i);

  // Exact sums are kept in 66 bits so no intermediate overflow can occur.
  assign sum_c = 66'(cc) - 66'(ss) + HALF;
  assign sum_s = 66'(sc) + 66'(cs) + HALF;
  assign shf_c = sum_c >>> FRAC_BITS;
  assign shf_s = sum_s >>> FRAC_BITS;

  always_comb begin
    if (shf_c > SAT_HI) begin
      cos_rot = 32'sh7FFF_FFFF;
    end else if (shf_c < SAT_LO) begin
      cos_rot = 32'sh8000_0000;
    end else begin
      cos_rot = shf_c[WORD_W-1:0];
    end
    if (shf_s > SAT_HI) begin
      sin_rot = 32'sh7FFF_FFFF;
    end else if (shf_s < SAT_LO) begin
      sin_rot = 32'sh8000_0000;
    end else begin
      sin_rot = shf_s[WORD_W-1:0];
    end
  end

  always_comb begin
    cos_d = cos_q;
    sin_d = sin_q;
    if (ctrl_i.advance) begin
      if (ctrl_i.rewind) begin
        cos_d = ROT_ONE;
        sin_d = '0;
      end else begin
        cos_d = cos_rot;
        sin_d = sin_rot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= ROT_ONE;
      sin_q <= '0;
    end else begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

endmodule

// ===== hdl/nwg_window_sum.sv =====
// Weighted cosine sum of the three rotators, rounded and clamped to 0..1.0.
// Depends on nwg_pkg.
module nwg_window_sum import nwg_pkg::*; (
  input  logic signed [WORD_W-1:0] cos1_i,
  input  logic signed [WORD_W-1:0] cos2_i,
  input  logic signed [WORD_W-1:0] cos3_i,
  output logic [VALUE_W-1:0]       value_o
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (COEF_BITS - 1);

  logic signed [63:0] p1, p2, p3, acc, rnd, w;

  assign p1  = 64'(cos1_i) * A1_C;
  assign p2  = 64'(cos2_i) * A2_C;
  assign p3  = 64'(cos3_i) * A3_C;
  assign acc = p1 - p2 + p3;
  assign rnd = (acc + HALF) >>> COEF_BITS;
  assign w   = A0_F - rnd;

  always_comb begin
    if (w < 0) begin
      value_o = '0;
    end else if (w > ONE_VAL) begin
      value_o = WIN_ONE;
    end else begin
      value_o = w[VALUE_W-1:0];
    end
  end

endmodule

// ===== hdl/nwg_out_buffer.sv =====
// Two-entry output register with skid stage for the result stream.
// Depends on nwg_pkg.
module nwg_out_buffer import nwg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  out_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      main_valid_q, skid_valid_q;
  out_item_t main_q, skid_q;
  logic      push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = main_valid_q && out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push;
      end
    end else if (push) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push) begin
        main_q <= in_item_i;
      end
    end else if (push) begin
      if (main_valid_q) begin
        skid_q <= in_item_i;
      end else begin
        main_q <= in_item_i;
      end
    end
  end

endmodule

// ===== hdl/nuttall_window_generator_unit.sv =====
// Top level of the Nuttall window generator: config registers, sample counter,
// three rotators, weighted sum and output buffer. Depends on nwg_pkg and all nwg_* modules.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[0] restart
//   m_axis    out        tdata[30:0] window_value, tdata[46:31] sample_index; tlast last
//   cfg       in         cfg_index_i selects register 0..6, cfg_wdata_i holds its value
//
// One sample per clock while s_axis_tready is high: a transaction is accepted in each
// such cycle and its result is registered in the output buffer before it is presented.
// The rotator update (four 32x32 products, add, round, saturate) and the weighted sum
// (three products, add, round, clamp) are combinational and set the cycle time. After
// reset the rotators are at (1,0), the counter is zero and no clearing pass is needed.
// A two-entry output buffer absorbs stalls; s_axis_tready drops only when both are full.
module nuttall_window_generator_unit import nwg_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [0] restart
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // [30:0] window_value, [46:31] sample_index
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i
);

  localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

  logic [LEN_W-1:0]         len_q;
  logic signed [WORD_W-1:0] cos1_q, sin1_q, cos2_q, sin2_q, cos3_q, sin3_q;
  logic [COUNT_BITS-1:0]    cnt_q, cnt_d, cnt_pre;
  logic [CMP_W-1:0]         cnt_ext, len_last;
  logic signed [WORD_W-1:0] c1, c2, c3;
  logic [VALUE_W-1:0]       sum_value;
  logic                     accept, restart, short_win, at_last;
  rot_ctrl_t                rot_ctrl;
  out_item_t                item, out_item;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign restart   = s_axis_tdata[0];
  assign short_win = (len_q <= LEN_W'(1));

  assign cnt_pre  = restart ? '0 : cnt_q;
  assign cnt_ext  = CMP_W'(cnt_pre);
  assign len_last = CMP_W'(len_q - LEN_W'(1));
  assign at_last  = (cnt_ext >= len_last);

  assign rot_ctrl.advance = accept;
  assign rot_ctrl.restart = restart;
  assign rot_ctrl.rewind  = short_win || at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      cos1_q <= STEP_ONE;
      sin1_q <= '0;
      cos2_q <= STEP_ONE;
      sin2_q <= '0;
      cos3_q <= STEP_ONE;
      sin3_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_WINDOW_LENGTH:  len_q  <= cfg_wdata_i[LEN_W-1:0];
        REG_COS_STEP_ONE:   cos1_q <= cfg_wdata_i;
        REG_SIN_STEP_ONE:   sin1_q <= cfg_wdata_i;
        REG_COS_STEP_TWO:   cos2_q <= cfg_wdata_i;
        REG_SIN_STEP_TWO:   sin2_q <= cfg_wdata_i;
        REG_COS_STEP_THREE: cos3_q <= cfg_wdata_i;
        REG_SIN_STEP_THREE: sin3_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (rot_ctrl.rewind) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_pre + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  nwg_rotator u_rot1 (
    .clk_i, .rst_ni, .ctrl_i(rot_ctrl),
    .cos_step_i(cos1_q), .sin_step_i(sin1_q), .cos_o(c1)
  );

  nwg_rotator u_rot2 (
    .clk_i, .rst_ni, .ctrl_i(rot_ctrl),
    .cos_step_i(cos2_q), .sin_step_i(sin2_q), .cos_o(c2)
  );

  nwg_rotator u_rot3 (
    .clk_i, .rst_ni, .ctrl_i(rot_ctrl),
    .cos_step_i(cos3_q), .sin_step_i(sin3_q), .cos_o(c3)
  );

  nwg_window_sum u_sum (
    .cos1_i(c1), .cos2_i(c2), .cos3_i(c3), .value_o(sum_value)
  );

  // A window of one sample (or zero) is always 1.0 at index zero.
  always_comb begin
    if (short_win) begin
      item.window_value = WIN_ONE;
      item.sample_index = '0;
      item.last         = 1'b1;
    end else begin
      item.window_value = sum_value;
      item.sample_index = cnt_ext[INDEX_W-1:0];
      item.last         = at_last;
    end
  end

  nwg_out_buffer u_obuf (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_item_o(out_item)
  );

  assign m_axis_tdata = {1'b0, out_item.sample_index, out_item.window_value};
  assign m_axis_tlast = out_item.last;

endmodule
